[design/point_density_gradient_core_defines.svh]
// assertion macros for the density and gradient core
`ifndef POINT_DENSITY_GRADIENT_CORE_DEFINES_SVH
`define POINT_DENSITY_GRADIENT_CORE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define PDG_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdg check failed");

// next-cycle implication, checked while out of reset
`define PDG_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdg check failed");

`endif

[design/pdg_pkg.sv]
// shared types, constants and saturating add for the density and gradient core
package pdg_pkg;

    localparam int MAX_FUNCS = 64;
    localparam int IDX_W     = $clog2(MAX_FUNCS);
    localparam int MADDR_W   = 2 * IDX_W;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int N_TERMS   = 7;
    localparam int TERM_W    = $clog2(N_TERMS);

    localparam logic KIND_MATRIX = 1'b0;
    localparam logic KIND_BASIS  = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic                     kind;
        logic [5:0]               row_index;
        logic [5:0]               col_index;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] grad_x_in;
        logic signed [DATA_W-1:0] grad_y_in;
        logic signed [DATA_W-1:0] grad_z_in;
        logic                     last_function;
    } in_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] density;
        logic signed [ACC_W-1:0] density_dx;
        logic signed [ACC_W-1:0] density_dy;
        logic signed [ACC_W-1:0] density_dz;
        logic                    saturated;
    } out_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] gx;
        logic signed [DATA_W-1:0] gy;
        logic signed [DATA_W-1:0] gz;
    } basis_t;

    typedef struct packed {
        logic               m_we;
        logic [MADDR_W-1:0] m_waddr;
        logic [DATA_W-1:0]  m_wdata;
        logic               b_we;
        logic [IDX_W-1:0]   b_waddr;
        basis_t             b_wdata;
        logic               re;
        logic [IDX_W-1:0]   r_row;
        logic [IDX_W-1:0]   r_col;
    } store_ctl_t;

    typedef struct packed {
        logic clear;
        logic in_v;
    } mac_ctl_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] w;
        logic signed [ACC_W-1:0] wx;
        logic signed [ACC_W-1:0] wy;
        logic signed [ACC_W-1:0] wz;
        logic                    ovf;
        logic                    pend;
    } mac_stat_t;

    typedef struct packed {
        logic                    ovf;
        logic signed [ACC_W-1:0] val;
    } sat_t;

    function automatic sat_t sat_add(logic signed [ACC_W-1:0] a,
                                     logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        sat_t res;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        res.ovf = s[ACC_W] != s[ACC_W-1];
        if (res.ovf)
            res.val = s[ACC_W] ? ACC_MIN : ACC_MAX;
        else
            res.val = s[ACC_W-1:0];
        return res;
    endfunction

endpackage

[design/pdg_store.sv]
// matrix memory and basis memory, one write and one registered read each
module pdg_store (
    input  logic                       clk,
    input  pdg_pkg::store_ctl_t        ctl,
    output logic signed [31:0]         p_q,
    output pdg_pkg::basis_t            basis_q
);
    import pdg_pkg::*;

    logic [DATA_W-1:0] matrix_mem [MAX_FUNCS*MAX_FUNCS];
    basis_t            basis_mem  [MAX_FUNCS];

    always_ff @(posedge clk)
    begin
        if (ctl.m_we)
            matrix_mem[ctl.m_waddr] <= ctl.m_wdata;
        if (ctl.re)
            p_q <= matrix_mem[{ctl.r_row, ctl.r_col}];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.b_we)
            basis_mem[ctl.b_waddr] <= ctl.b_wdata;
        if (ctl.re)
            basis_q <= basis_mem[ctl.r_col];
    end

endmodule

[design/pdg_mac.sv]
// four-lane multiply-accumulate for the row sums w, wx, wy, wz
module pdg_mac (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pdg_pkg::mac_ctl_t    ctl,
    input  logic signed [31:0]   p,
    input  pdg_pkg::basis_t      f,
    output pdg_pkg::mac_stat_t   stat
);
    import pdg_pkg::*;

    logic signed [ACC_W-1:0] prod_reg [4];
    logic signed [ACC_W-1:0] acc_reg  [4];
    logic signed [ACC_W-1:0] acc_next [4];
    logic                    prod_v_reg;
    logic                    ovf_reg;
    logic                    ovf_next;
    sat_t                    s [4];

    always_ff @(posedge clk)
    begin
        if (ctl.in_v)
        begin
            prod_reg[0] <= ACC_W'(p) * ACC_W'(f.value);
            prod_reg[1] <= ACC_W'(p) * ACC_W'(f.gx);
            prod_reg[2] <= ACC_W'(p) * ACC_W'(f.gy);
            prod_reg[3] <= ACC_W'(p) * ACC_W'(f.gz);
        end
    end

    always_comb
    begin
        ovf_next = ovf_reg;
        for (int k = 0; k < 4; k++)
        begin
            s[k] = sat_add(acc_reg[k], prod_reg[k]);
            acc_next[k] = acc_reg[k];
            if (ctl.clear)
                acc_next[k] = '0;
            else if (prod_v_reg)
            begin
                acc_next[k] = s[k].val;
                ovf_next = ovf_next | s[k].ovf;
            end
        end
        if (ctl.clear)
            ovf_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            for (int k = 0; k < 4; k++)
                acc_reg[k] <= '0;
        end
        else
        begin
            prod_v_reg <= ctl.in_v;
            ovf_reg    <= ovf_next;
            for (int k = 0; k < 4; k++)
                acc_reg[k] <= acc_next[k];
        end
    end

    assign stat.w    = acc_reg[0];
    assign stat.wx   = acc_reg[1];
    assign stat.wy   = acc_reg[2];
    assign stat.wz   = acc_reg[3];
    assign stat.ovf  = ovf_reg;
    assign stat.pend = prod_v_reg;

endmodule

[design/pdg_mulq.sv]
// q16.16 times q32.32, shifted right 16 toward zero and saturated; done marks r and ovf ready
module pdg_mulq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic signed [31:0]  a,
    input  logic signed [63:0]  b,
    output logic                done,
    output logic signed [63:0]  r,
    output logic                ovf
);
    import pdg_pkg::*;

    logic [3:0]        v_reg;
    logic              neg_reg;
    logic [31:0]       ua_reg;
    logic [63:0]       ub_reg;
    logic [63:0]       x_reg;
    logic [63:0]       y_reg;
    logic [63:0]       mag_reg;
    logic              sat_reg;
    logic [63:0]       mag_next;
    logic [63:0]       lim;
    logic              sat_next;
    logic signed [63:0] r_reg;
    logic               ovf_reg;

    always_comb
    begin
        lim = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        mag_next = {x_reg[47:0], 16'b0} + {16'b0, y_reg[63:16]};
        sat_next = (x_reg > 64'h0000_8000_0000_0000) || (mag_next > lim);
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            neg_reg <= a[31] ^ b[63];
            ua_reg  <= a[31] ? 32'(-a) : 32'(a);
            ub_reg  <= b[63] ? 64'(-b) : 64'(b);
        end
        if (v_reg[0])
            x_reg <= 64'(ua_reg) * 64'(ub_reg[63:32]);
        if (v_reg[1])
            y_reg <= 64'(ua_reg) * 64'(ub_reg[31:0]);
        if (v_reg[2])
        begin
            mag_reg <= mag_next;
            sat_reg <= sat_next;
        end
        if (v_reg[3])
        begin
            ovf_reg <= sat_reg;
            if (sat_reg)
                r_reg <= neg_reg ? ACC_MIN : ACC_MAX;
            else
                r_reg <= neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            done  <= 1'b0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], go};
            done  <= v_reg[3];
        end
    end

    assign r   = r_reg;
    assign ovf = ovf_reg;

endmodule

[design/point_density_gradient_core.sv]
// density and gradient core: control sequencer over the stores, mac and term multiplier
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------
//  input    | start / busy       | item   (pdg_pkg::in_t)
//  result   | valid, one cycle   | result (pdg_pkg::out_t)
//
// a matrix item with col_index <= row_index is written in its accept cycle; busy stays low
// basis function i holds busy through i + 1 memory reads, a drain of the mac,
//   seven passes through the term multiplier and three adds of the gradient
//   pairs, and through a finish step when it ends a point
// the result is valid in the cycle after the finish step, with busy already low
// rst_n clears the sequencer and the sums; memory contents stay undefined
// results cannot be held off by the receiver
module point_density_gradient_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  pdg_pkg::in_t    item,
    output logic            valid,
    output pdg_pkg::out_t   result
);
    import pdg_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOOP   = 7'b0000010,
        S_DRAIN  = 7'b0000100,
        S_MUL    = 7'b0001000,
        S_WAIT   = 7'b0010000,
        S_ACC    = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    in_t                     item_reg;
    logic [IDX_W-1:0]        j_reg, j_next;
    logic [TERM_W-1:0]       k_reg, k_next;
    logic                    rd_v_reg;
    logic signed [ACC_W-1:0] sum_reg  [4];
    logic signed [ACC_W-1:0] sum_next [4];
    logic signed [ACC_W-1:0] tmp_reg, tmp_next;
    logic                    ovf_reg, ovf_next;
    logic                    valid_reg, valid_next;
    out_t                    result_reg;

    store_ctl_t              sctl;
    mac_ctl_t                mctl;
    mac_stat_t               mstat;
    logic signed [31:0]      p_q;
    basis_t                  basis_q;

    logic                    accept;
    logic                    mq_go, mq_done, mq_ovf;
    logic signed [31:0]      mq_a;
    logic signed [63:0]      mq_b;
    logic signed [63:0]      mq_r;
    sat_t                    s_sum, s_tmp;
    logic [1:0]              sel;

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        sctl.m_we    = accept && (item.kind == KIND_MATRIX)
                       && (item.col_index <= item.row_index);
        sctl.m_waddr = {item.row_index, item.col_index};
        sctl.m_wdata = item.value;
        sctl.b_we    = accept && (item.kind == KIND_BASIS);
        sctl.b_waddr = item.row_index;
        sctl.b_wdata = '{value: item.value, gx: item.grad_x_in,
                         gy: item.grad_y_in, gz: item.grad_z_in};
        sctl.re      = (state_reg == S_LOOP);
        sctl.r_row   = item_reg.row_index;
        sctl.r_col   = j_reg;
        mctl.clear   = sctl.b_we;
        mctl.in_v    = rd_v_reg;
    end

    pdg_store u_store (
        .clk     (clk),
        .ctl     (sctl),
        .p_q     (p_q),
        .basis_q (basis_q)
    );

    pdg_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .p     (p_q),
        .f     (basis_q),
        .stat  (mstat)
    );

    // term order: v*w, gx*w, v*wx, gy*w, v*wy, gz*w, v*wz
    always_comb
    begin
        case (k_reg)
            3'd1:    mq_a = item_reg.grad_x_in;
            3'd3:    mq_a = item_reg.grad_y_in;
            3'd5:    mq_a = item_reg.grad_z_in;
            default: mq_a = item_reg.value;
        endcase
        case (k_reg)
            3'd2:    mq_b = mstat.wx;
            3'd4:    mq_b = mstat.wy;
            3'd6:    mq_b = mstat.wz;
            default: mq_b = mstat.w;
        endcase
    end

    pdg_mulq u_mulq (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mq_go),
        .a     (mq_a),
        .b     (mq_b),
        .done  (mq_done),
        .r     (mq_r),
        .ovf   (mq_ovf)
    );

    assign sel   = 2'(k_reg[TERM_W-1:1]);
    assign s_tmp = sat_add(tmp_reg, mq_r);
    assign s_sum = sat_add(sum_reg[sel], (state_reg == S_ACC) ? tmp_reg : mq_r);

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        tmp_next   = tmp_reg;
        ovf_next   = ovf_reg;
        valid_next = 1'b0;
        mq_go      = 1'b0;
        for (int n = 0; n < 4; n++)
            sum_next[n] = sum_reg[n];

        case (state_reg)
            S_IDLE:
            begin
                if (accept && item.kind == KIND_BASIS)
                begin
                    j_next     = '0;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                j_next = j_reg + 1'b1;
                if (j_reg == item_reg.row_index)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!rd_v_reg && !mstat.pend)
                begin
                    ovf_next   = ovf_reg | mstat.ovf;
                    k_next     = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                mq_go      = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (mq_done)
                begin
                    if (k_reg == '0)
                    begin
                        sum_next[0] = s_sum.val;
                        ovf_next    = ovf_reg | mq_ovf | s_sum.ovf;
                        k_next      = k_reg + 1'b1;
                        state_next  = S_MUL;
                    end
                    else if (k_reg[0])
                    begin
                        tmp_next   = mq_r;
                        ovf_next   = ovf_reg | mq_ovf;
                        k_next     = k_reg + 1'b1;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        tmp_next   = s_tmp.val;
                        ovf_next   = ovf_reg | mq_ovf | s_tmp.ovf;
                        state_next = S_ACC;
                    end
                end
            end
            S_ACC:
            begin
                sum_next[sel] = s_sum.val;
                ovf_next      = ovf_reg | s_sum.ovf;
                if (k_reg == TERM_W'(N_TERMS - 1))
                    state_next = item_reg.last_function ? S_FINISH : S_IDLE;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_FINISH:
            begin
                valid_next = 1'b1;
                ovf_next   = 1'b0;
                for (int n = 0; n < 4; n++)
                    sum_next[n] = '0;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sctl.b_we)
            item_reg <= item;
        tmp_reg <= tmp_next;
        if (state_reg == S_FINISH)
            result_reg <= '{density: sum_reg[0], density_dx: sum_reg[1],
                            density_dy: sum_reg[2], density_dz: sum_reg[3],
                            saturated: ovf_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
            k_reg     <= '0;
            rd_v_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
            for (int n = 0; n < 4; n++)
                sum_reg[n] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            rd_v_reg  <= (state_reg == S_LOOP);
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
            for (int n = 0; n < 4; n++)
                sum_reg[n] <= sum_next[n];
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign valid  = valid_reg;
    assign result = result_reg;

endmodule

[design/pdg_checker.sv]
// port-level checks on the density and gradient core, bound to the top level
`include "point_density_gradient_core_defines.svh"

module pdg_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input pdg_pkg::in_t    item,
    input logic            valid,
    input pdg_pkg::out_t   result
);
    import pdg_pkg::*;

    logic matrix_acc, basis_acc;

    assign matrix_acc = start && !busy && (item.kind == KIND_MATRIX);
    assign basis_acc  = start && !busy && (item.kind == KIND_BASIS);

    // a result only shows once the work on its item is over
    `PDG_ASSERT_IMP(a_valid_idle, valid, !busy)
    // a result is a single-cycle pulse
    `PDG_ASSERT_NXT(a_valid_pulse, valid, !valid)
    // matrix writes finish in their accept cycle
    `PDG_ASSERT_NXT(a_matrix_fast, matrix_acc, !busy && !valid)
    // basis items always occupy the block
    `PDG_ASSERT_NXT(a_basis_busy, basis_acc, busy)
    // a shown result carries no unknown bits
    `PDG_ASSERT_IMP(a_result_known, valid, !$isunknown(result))

endmodule

bind point_density_gradient_core pdg_checker u_pdg_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .valid  (valid),
    .result (result)
);

[tb/point_density_gradient_core_tb.sv]
// self-checking testbench for the density and gradient core: predicted point results vs block output
module point_density_gradient_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pdg_pkg::*;

    // basis indexes used by the stimulus; matrix rows below this are all written first
    localparam int TB_FUNCS = 32;

    class point_scoreboard;
        logic signed [31:0] pmat [0:4095];
        logic signed [31:0] fval [0:63];
        logic signed [31:0] fgx [0:63];
        logic signed [31:0] fgy [0:63];
        logic signed [31:0] fgz [0:63];
        logic signed [63:0] acc_d, acc_x, acc_y, acc_z;
        bit ovf;
        out_t pending_points [$];
        int errors;

        function new();
            acc_d = 0; acc_x = 0; acc_y = 0; acc_z = 0;
            ovf = 0; errors = 0;
            foreach (pmat[k]) pmat[k] = 0;
            foreach (fval[k]) begin
                fval[k] = 0; fgx[k] = 0; fgy[k] = 0; fgz[k] = 0;
            end
        endfunction

        function logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63]) begin
                ovf = 1;
                return s[64] ? ACC_MIN : ACC_MAX;
            end
            return s[63:0];
        endfunction

        // q16.16 times q32.32, shifted 16 toward zero, saturated
        function logic signed [63:0] mulq(logic signed [31:0] a, logic signed [63:0] b);
            logic signed [96:0] p;
            logic [96:0] m;
            logic signed [96:0] r;
            p = $signed(a) * $signed(b);
            m = p[96] ? -p : p;
            m = m >> 16;
            r = p[96] ? -$signed(m) : $signed(m);
            if (r > $signed(97'(ACC_MAX))) begin ovf = 1; return ACC_MAX; end
            if (r < -$signed({1'b0, 96'h1 << 63})) begin ovf = 1; return ACC_MIN; end
            return r[63:0];
        endfunction

        function void note_item(in_t it);
            logic signed [63:0] w, wx, wy, wz, p;
            out_t o;
            int r;
            r = it.row_index;
            if (it.kind == KIND_MATRIX) begin
                if (it.col_index <= it.row_index) pmat[r*64 + it.col_index] = it.value;
                return;
            end
            fval[r] = it.value; fgx[r] = it.grad_x_in;
            fgy[r] = it.grad_y_in; fgz[r] = it.grad_z_in;
            w = 0; wx = 0; wy = 0; wz = 0;
            for (int j = 0; j <= r; j++) begin
                p = pmat[r*64 + j];
                w = sadd(w, p * fval[j]);
                wx = sadd(wx, p * fgx[j]);
                wy = sadd(wy, p * fgy[j]);
                wz = sadd(wz, p * fgz[j]);
            end
            acc_d = sadd(acc_d, mulq(it.value, w));
            acc_x = sadd(acc_x, sadd(mulq(it.grad_x_in, w), mulq(it.value, wx)));
            acc_y = sadd(acc_y, sadd(mulq(it.grad_y_in, w), mulq(it.value, wy)));
            acc_z = sadd(acc_z, sadd(mulq(it.grad_z_in, w), mulq(it.value, wz)));
            if (it.last_function) begin
                o.density = acc_d; o.density_dx = acc_x;
                o.density_dy = acc_y; o.density_dz = acc_z; o.saturated = ovf;
                pending_points.push_back(o);
                acc_d = 0; acc_x = 0; acc_y = 0; acc_z = 0; ovf = 0;
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        endtask

        task check_result(out_t got);
            out_t e;
            if (pending_points.size() == 0) begin
                report("unexpected result", got.density, '0);
                return;
            end
            e = pending_points.pop_front();
            if (got.density !== e.density) report("density", got.density, e.density);
            if (got.density_dx !== e.density_dx) report("dx", got.density_dx, e.density_dx);
            if (got.density_dy !== e.density_dy) report("dy", got.density_dy, e.density_dy);
            if (got.density_dz !== e.density_dz) report("dz", got.density_dz, e.density_dz);
            if (got.saturated !== e.saturated) report("saturated", got.saturated, e.saturated);
        endtask
    endclass

    logic clk = 0, rst_n = 0, start = 0, busy, valid;
    in_t item = '0;
    out_t result;
    point_scoreboard sb = new();
    bit quiet_phase = 0;
    int sent = 0;

    point_density_gradient_core i_dut (.clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .item(item), .valid(valid), .result(result));

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
        if (rst_n && valid) sb.check_result(result);

    function logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 131072)) - 65536;
            3: return 0;
            default: return $urandom();
        endcase
    endfunction

    // start stays high on return; wait_drain takes it down, and so may the next item outside the quiet phase
    task automatic send_item(in_t it);
        if (!quiet_phase)
            while ($urandom_range(0, 99) < 33) begin
                start <= 0;
                @(negedge clk);
            end
        start <= 1;
        item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_item(it);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_matrix(int r, int c, logic signed [31:0] v);
        in_t it;
        it = '0;
        it.kind = KIND_MATRIX; it.row_index = 6'(r); it.col_index = 6'(c); it.value = v;
        it.grad_x_in = $urandom(); it.last_function = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic send_basis(int r, bit last, logic signed [31:0] v, logic signed [31:0] gx,
                              logic signed [31:0] gy, logic signed [31:0] gz);
        in_t it;
        it.kind = KIND_BASIS; it.row_index = 6'(r); it.col_index = 6'($urandom_range(0, 63));
        it.value = v; it.grad_x_in = gx; it.grad_y_in = gy; it.grad_z_in = gz;
        it.last_function = last;
        send_item(it);
    endtask

    task automatic wait_drain();
        start <= 0;
        while (sb.pending_points.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic run_point(int n);
        for (int i = 0; i < n; i++)
            send_basis(i, i == n - 1, rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    initial begin
        int n;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // every row in use written once so no read ever hits an unwritten entry
        for (int r = 0; r < TB_FUNCS; r++)
            for (int c = 0; c <= r; c++)
                send_matrix(r, c, rand_word());
        // every basis index in use written once as well
        run_point(TB_FUNCS);
        // column above row is ignored
        send_matrix(3, 9, 32'sh7fffffff);
        // directed: single function, extremes, saturating point
        send_basis(0, 1, 32'sh00010000, 32'sh7fffffff, 32'sh80000000, 0);
        send_matrix(0, 0, 32'sh7fffffff);
        send_basis(0, 1, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        send_basis(0, 1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_matrix(1, 0, 32'sh80000000);
        send_matrix(1, 1, 32'sh80000000);
        send_basis(0, 0, 32'sh7fffffff, 1, -1, 0);
        send_basis(1, 1, 32'sh80000000, 32'sh7fffffff, 0, -1);
        // out-of-order: high index alone reuses stale lower values
        send_basis(TB_FUNCS - 1, 1, 32'sh00020000, 0, 0, 0);
        send_basis(5, 0, 32'sh00008000, 1, 2, 3);
        send_basis(2, 1, -32'sh00008000, 3, 2, 1);
        wait_drain();
        quiet_phase = 1;
        run_point(TB_FUNCS);
        run_point(8);
        run_point(3);
        quiet_phase = 0;
        while (sent < 1100) begin
            case ($urandom_range(0, 9))
                0: send_matrix($urandom_range(0, 63), $urandom_range(0, 63), rand_word());
                1: send_basis($urandom_range(0, TB_FUNCS - 1), $urandom_range(0, 1),
                              rand_word(), rand_word(), rand_word(), rand_word());
                default: begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, TB_FUNCS)
                                                    : $urandom_range(1, 6);
                    run_point(n);
                end
            endcase
            if ($urandom_range(0, 40) == 0) wait_drain();
        end
        wait_drain();
        if (sb.errors == 0 && sb.pending_points.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
